### design/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation block.
// Holds the channel payload structs, the divider stage types and register indexes.
// No dependencies.
package bpc_pkg;

   // Input item: raw temperature word and the three raw pressure bytes.
   typedef struct packed {
      logic [15:0] raw_temp;
      logic [7:0]  press_msb;
      logic [7:0]  press_lsb;
      logic [7:0]  press_xlsb;
   } req_type;

   // Result item: compensated temperature, pressure and the divide error flag.
   typedef struct packed {
      logic signed [15:0] temperature;
      logic [17:0]        pressure;
      logic               div_error;
   } rsp_type;

   // Configuration register indexes.
   localparam int CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_CAL_A = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CAL_B = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CAL_C = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_CAL_D = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_CAL_E = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_OSS   = 3'd5;

   // Number of quotient bits, one per divider cell.
   localparam int DivSteps = 32;
   localparam int UpWidth  = 19;

   // Data that rides alongside a division through the cell chain.
   typedef struct packed {
      logic [31:0]        word;
      logic [UpWidth-1:0] up;
      logic               neg;
      logic               err;
   } side_type;

   // One stage of the divider chain.
   typedef struct packed {
      logic        valid;
      logic [31:0] rem;
      logic [31:0] num;
      logic [31:0] den;
      logic [31:0] quo;
      side_type    side;
   } div_stage_type;

endpackage

### design/bpc_div_cell.sv
// One restoring division cell: produces one quotient bit per stage.
// Depends on bpc_pkg for the stage type.
module bpc_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  bpc_pkg::div_stage_type prev_stage,
   output bpc_pkg::div_stage_type next_stage
);
   import bpc_pkg::*;

   div_stage_type stage_ff;
   div_stage_type stage_in;

   // Shift in the next dividend bit and try to subtract the divisor.
   always_comb begin
      logic [32:0] trial;
      logic [32:0] diff;
      trial    = {prev_stage.rem, prev_stage.num[31]};
      diff     = trial - {1'b0, prev_stage.den};
      stage_in = prev_stage;
      stage_in.num = {prev_stage.num[30:0], 1'b0};
      if (!diff[32]) begin
         stage_in.rem = diff[31:0];
         stage_in.quo = {prev_stage.quo[30:0], 1'b1};
      end else begin
         stage_in.rem = trial[31:0];
         stage_in.quo = {prev_stage.quo[30:0], 1'b0};
      end
   end

   // Stage register; only the valid bit is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign next_stage = stage_ff;

endmodule

### design/bpc_div_chain.sv
// Row of division cells forming a pipelined unsigned 32-bit divider.
// Depends on bpc_pkg and bpc_div_cell.
module bpc_div_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  bpc_pkg::div_stage_type head,
   output bpc_pkg::div_stage_type tail
);
   import bpc_pkg::*;

   div_stage_type link [DivSteps+1];

   assign link[0] = head;

   // Each cell hands its partial remainder to the next on every enabled cycle.
   for (genvar i = 0; i < DivSteps; i++) begin : g_cell
      bpc_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .prev_stage (link[i]),
         .next_stage (link[i+1])
      );
   end

   assign tail = link[DivSteps];

endmodule

### design/barometric_pressure_compensation_top.sv
// Top level of the barometric pressure compensation block.
// Depends on bpc_pkg and bpc_div_chain.
//
// Usage: items arrive on the req_ channel (valid/ready) carrying a raw
// temperature word and three raw pressure bytes; one result per item leaves
// on the rsp_ channel with temperature in 0.1 degree units, pressure in
// pascals and a divide error flag. Calibration words and the oversampling
// setting are written on the csr_ channel, which is always ready. The user
// must see that writes are made only while no item is in flight; the block
// itself does not enforce this. The datapath is a single pipeline with two
// chains of 32 division cells, one quotient bit per cell. A new item is
// accepted in every cycle unless the receiver stalls, so throughput is one
// item per cycle. When the receiver stalls with a result waiting, the whole
// pipeline holds and req_ready drops in the same cycle; nothing is lost.
// Reset clears the calibration registers and all valid bits.
module barometric_pressure_compensation_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  bpc_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bpc_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bpc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [31:0]                        csr_data
);
   import bpc_pkg::*;

   localparam logic signed [31:0] TempOffset = 32'sd4000;
   localparam logic signed [31:0] CoefA      = 32'sd3038;
   localparam logic signed [31:0] CoefB      = -32'sd7357;
   localparam logic signed [31:0] CoefC      = 32'sd3791;
   localparam logic [31:0]        PressScale = 32'd50000;

   // Configuration registers.
   logic [31:0] cal_a_ff, cal_b_ff, cal_c_ff, cal_d_ff, cal_e_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_c_ff <= '0;
         cal_d_ff <= '0;
         cal_e_ff <= '0;
         oss_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CAL_A: cal_a_ff <= csr_data;
            CSR_CAL_B: cal_b_ff <= csr_data;
            CSR_CAL_C: cal_c_ff <= csr_data;
            CSR_CAL_D: cal_d_ff <= csr_data;
            CSR_CAL_E: cal_e_ff <= csr_data;
            CSR_OSS:   oss_ff   <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Calibration words widened to 32 bits.
   logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = {{16{cal_a_ff[31]}}, cal_a_ff[31:16]};
   assign ac2 = {{16{cal_a_ff[15]}}, cal_a_ff[15:0]};
   assign ac3 = {{16{cal_b_ff[31]}}, cal_b_ff[31:16]};
   assign ac4 = {16'b0, cal_b_ff[15:0]};
   assign ac5 = {16'b0, cal_c_ff[31:16]};
   assign ac6 = {16'b0, cal_c_ff[15:0]};
   assign b1  = {{16{cal_d_ff[31]}}, cal_d_ff[31:16]};
   assign b2  = {{16{cal_d_ff[15]}}, cal_d_ff[15:0]};
   assign mc  = {{16{cal_e_ff[31]}}, cal_e_ff[31:16]};
   assign md  = {{16{cal_e_ff[15]}}, cal_e_ff[15:0]};

   // Whole pipeline advances unless a result waits on a stalled receiver.
   logic    enable;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   assign enable    = !rsp_valid_ff || rsp_ready;
   assign req_ready = enable;

   // Stage A: first temperature product and raw pressure assembly.
   logic               a_valid_ff;
   logic signed [31:0] a_mul_ff;
   logic [UpWidth-1:0] a_up_ff;

   always_ff @(posedge clock) begin
      logic [23:0]        raw24;
      logic [3:0]         amt;
      logic signed [31:0] ut;
      raw24 = {req_payload.press_msb, req_payload.press_lsb, req_payload.press_xlsb};
      amt   = 4'd8 - {2'b0, oss_ff};
      ut    = {16'b0, req_payload.raw_temp};
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= req_valid;
         a_mul_ff   <= (ut - ac6) * ac5;
         a_up_ff    <= UpWidth'(raw24 >> amt);
      end
   end

   // Temperature divider set-up: magnitudes into the first cell chain.
   div_stage_type head1, tail1;

   always_comb begin
      logic signed [31:0] x1;
      logic signed [31:0] den;
      logic signed [31:0] num;
      x1  = a_mul_ff >>> 15;
      den = x1 + md;
      num = mc <<< 11;
      head1.valid     = a_valid_ff;
      head1.rem       = '0;
      head1.quo       = '0;
      head1.num       = num[31] ? 32'(-num) : num;
      head1.den       = den[31] ? 32'(-den) : den;
      head1.side.word = x1;
      head1.side.up   = a_up_ff;
      head1.side.neg  = num[31] ^ den[31];
      head1.side.err  = (den == 32'sd0);
   end

   bpc_div_chain u_div_temp (
      .clock  (clock),
      .reset  (reset),
      .enable (enable),
      .head   (head1),
      .tail   (tail1)
   );

   // Stage C: signed quotient and the B5 term.
   logic               c_valid_ff, c_err_ff;
   logic signed [31:0] c_b5_ff;
   logic [UpWidth-1:0] c_up_ff;

   always_ff @(posedge clock) begin
      logic signed [31:0] q;
      q = tail1.side.neg ? 32'(-tail1.quo) : tail1.quo;
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (enable) begin
         c_valid_ff <= tail1.valid;
         c_err_ff   <= tail1.side.err;
         c_b5_ff    <= $signed(tail1.side.word) + q;
         c_up_ff    <= tail1.side.up;
      end
   end

   // Stage D: temperature result and the square of B6.
   logic               d_valid_ff, d_err_ff;
   logic signed [15:0] d_t_ff;
   logic signed [31:0] d_b6_ff, d_sqp_ff;
   logic [UpWidth-1:0] d_up_ff;

   always_ff @(posedge clock) begin
      logic signed [31:0] t32;
      logic signed [31:0] b6;
      t32 = (c_b5_ff + 32'sd8) >>> 4;
      b6  = c_b5_ff - TempOffset;
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (enable) begin
         d_valid_ff <= c_valid_ff;
         d_err_ff   <= c_err_ff;
         d_b6_ff    <= b6;
         d_sqp_ff   <= b6 * b6;
         d_up_ff    <= c_up_ff;
         if (t32 > 32'sd32767) begin
            d_t_ff <= 16'sh7FFF;
         end else if (t32 < -32'sd32768) begin
            d_t_ff <= 16'sh8000;
         end else begin
            d_t_ff <= t32[15:0];
         end
      end
   end

   // Stage E: the four calibration products.
   logic               e_valid_ff, e_err_ff;
   logic signed [15:0] e_t_ff;
   logic signed [31:0] e_m0_ff, e_m1_ff, e_m2_ff, e_m3_ff;
   logic [UpWidth-1:0] e_up_ff;

   always_ff @(posedge clock) begin
      logic signed [31:0] sq;
      sq = d_sqp_ff >>> 12;
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (enable) begin
         e_valid_ff <= d_valid_ff;
         e_err_ff   <= d_err_ff;
         e_t_ff     <= d_t_ff;
         e_up_ff    <= d_up_ff;
         e_m0_ff    <= b2 * sq;
         e_m1_ff    <= ac2 * d_b6_ff;
         e_m2_ff    <= ac3 * d_b6_ff;
         e_m3_ff    <= b1 * sq;
      end
   end

   // Stage F: B3 and the B4 multiplicand.
   logic               f_valid_ff, f_err_ff;
   logic signed [15:0] f_t_ff;
   logic signed [31:0] f_b3_ff, f_u_ff;
   logic [UpWidth-1:0] f_up_ff;

   always_ff @(posedge clock) begin
      logic signed [31:0] x3a, v, x3b;
      x3a = (e_m0_ff >>> 11) + (e_m1_ff >>> 11);
      v   = (((ac1 <<< 2) + x3a) <<< oss_ff) + 32'sd2;
      x3b = ((e_m2_ff >>> 13) + (e_m3_ff >>> 16) + 32'sd2) >>> 2;
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (enable) begin
         f_valid_ff <= e_valid_ff;
         f_err_ff   <= e_err_ff;
         f_t_ff     <= e_t_ff;
         f_up_ff    <= e_up_ff;
         f_b3_ff    <= (v + (v[31] ? 32'sd3 : 32'sd0)) >>> 2;
         f_u_ff     <= x3b + 32'sd32768;
      end
   end

   // Stage G: B4 and the pressure difference.
   logic               g_valid_ff, g_err_ff;
   logic signed [15:0] g_t_ff;
   logic [31:0]        g_b4_ff, g_diff_ff;

   always_ff @(posedge clock) begin
      logic [31:0] prod;
      prod = ac4 * f_u_ff;
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (enable) begin
         g_valid_ff <= f_valid_ff;
         g_err_ff   <= f_err_ff;
         g_t_ff     <= f_t_ff;
         g_b4_ff    <= {15'b0, prod[31:15]};
         g_diff_ff  <= {13'b0, f_up_ff} - f_b3_ff;
      end
   end

   // Stage H: B7 and the zero divisor check.
   logic               h_valid_ff, h_err_ff;
   logic signed [15:0] h_t_ff;
   logic [31:0]        h_b4_ff, h_b7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (enable) begin
         h_valid_ff <= g_valid_ff;
         h_err_ff   <= g_err_ff || (g_b4_ff == 32'd0);
         h_t_ff     <= g_t_ff;
         h_b4_ff    <= g_b4_ff;
         h_b7_ff    <= g_diff_ff * (PressScale >> oss_ff);
      end
   end

   // Pressure divider set-up: double B7 before or after the division.
   div_stage_type head2, tail2;

   always_comb begin
      head2.valid     = h_valid_ff;
      head2.rem       = '0;
      head2.quo       = '0;
      head2.num       = h_b7_ff[31] ? h_b7_ff : {h_b7_ff[30:0], 1'b0};
      head2.den       = h_b4_ff;
      head2.side.word = {16'b0, h_t_ff};
      head2.side.up   = '0;
      head2.side.neg  = h_b7_ff[31];
      head2.side.err  = h_err_ff;
   end

   bpc_div_chain u_div_press (
      .clock  (clock),
      .reset  (reset),
      .enable (enable),
      .head   (head2),
      .tail   (tail2)
   );

   // Stage P1: raw pressure and its first correction products.
   logic               p1_valid_ff, p1_err_ff;
   logic signed [15:0] p1_t_ff;
   logic signed [31:0] p1_p_ff, p1_msq_ff, p1_mx2_ff;

   always_ff @(posedge clock) begin
      logic signed [31:0] p, ps;
      p  = tail2.side.neg ? {tail2.quo[30:0], 1'b0} : tail2.quo;
      ps = p >>> 8;
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (enable) begin
         p1_valid_ff <= tail2.valid;
         p1_err_ff   <= tail2.side.err;
         p1_t_ff     <= tail2.side.word[15:0];
         p1_p_ff     <= p;
         p1_msq_ff   <= ps * ps;
         p1_mx2_ff   <= CoefB * p;
      end
   end

   // Stage P2: scale the squared term and the linear term.
   logic               p2_valid_ff, p2_err_ff;
   logic signed [15:0] p2_t_ff;
   logic signed [31:0] p2_p_ff, p2_m1_ff, p2_x2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (enable) begin
         p2_valid_ff <= p1_valid_ff;
         p2_err_ff   <= p1_err_ff;
         p2_t_ff     <= p1_t_ff;
         p2_p_ff     <= p1_p_ff;
         p2_m1_ff    <= p1_msq_ff * CoefA;
         p2_x2_ff    <= p1_mx2_ff >>> 16;
      end
   end

   // Output register: final pressure, saturation and error handling.
   always_ff @(posedge clock) begin
      logic signed [31:0] sum, pn;
      sum = (p2_m1_ff >>> 16) + p2_x2_ff + CoefC;
      pn  = p2_p_ff + (sum >>> 4);
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= p2_valid_ff;
         if (p2_err_ff) begin
            rsp_ff.temperature <= '0;
            rsp_ff.pressure    <= '0;
            rsp_ff.div_error   <= 1'b1;
         end else begin
            rsp_ff.temperature <= p2_t_ff;
            rsp_ff.div_error   <= 1'b0;
            if (pn < 32'sd0) begin
               rsp_ff.pressure <= '0;
            end else if (pn > 32'sd262143) begin
               rsp_ff.pressure <= 18'h3FFFF;
            end else begin
               rsp_ff.pressure <= pn[17:0];
            end
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
